// File: src/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante.
`define SPQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check cons in the cycle after ante.
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/spq_pkg.sv
// Types and constants for the sorted priority queue.
package spq_pkg;

   localparam int FIELD_W = 32;
   localparam int COUNT_W = 7;

   typedef enum logic [0:0] {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      opcode_type                opcode;
      logic signed [FIELD_W-1:0] value;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic [COUNT_W-1:0]        count;
      logic                      top_valid;
      logic signed [FIELD_W-1:0] top_value;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PLACE,
      ST_POP_WAIT,
      ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      IDX_HOLD,
      IDX_ZERO,
      IDX_LAST,
      IDX_BELOW_LAST,
      IDX_DEC
   } idx_sel_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC
   } cnt_op_type;

   typedef enum logic [1:0] {
      TOP_HOLD,
      TOP_PUSH,
      TOP_READ
   } top_op_type;

   typedef enum logic [0:0] {
      WA_IDX,
      WA_IDX_UP
   } wr_addr_type;

   typedef struct packed {
      logic        capture;
      idx_sel_type idx_sel;
      logic        wr_en;
      wr_addr_type wr_addr;
      logic        wr_shift;
      cnt_op_type  cnt_op;
      top_op_type  top_op;
      logic        status_load;
      status_type  status;
      logic        rsp_load;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic single;
      logic greater;
      logic idx_zero;
      logic rsp_free;
   } sts_type;

endpackage

// File: src/sorted_priority_queue.sv
// Bounded priority queue of signed values, largest first; one result per push or pop.
// Entries sit in a single-port-write memory in ascending order, so the largest is the
// highest filled entry and a pop only moves the count and fetches the new top. A push walks
// down from the largest entry, moving one greater entry up per cycle until it finds its
// slot. A rejected transaction or a pop that empties the queue goes straight to the finish
// state; any other pop first waits in a state for the new top to be read, a push into an
// empty queue first writes its value in the place state, and any other push first scans
// past every held entry greater than the pushed value. The result register lets the next
// transaction be taken while a result still waits. No clearing pass follows reset.
module sorted_priority_queue #(
   parameter int CAPACITY    = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  spq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output spq_pkg::rsp_type rsp_data
);
   import spq_pkg::*;

   `include "assert_macros.svh"

   cmd_type cmd;
   sts_type sts;

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.opcode),
      .sts       (sts),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   spq_datapath #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   `SPQ_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall,
      "accepted transaction did not hold off the next one")
   `SPQ_ASSERT_NOW(a_full_count, clock, reset, rsp_valid && rsp_data.status == STATUS_FULL,
      rsp_data.count == COUNT_W'(CAPACITY), "full status with a count short of capacity")
   `SPQ_ASSERT_NOW(a_empty_result, clock, reset, rsp_valid && rsp_data.status == STATUS_EMPTY,
      rsp_data.count == '0 && !rsp_data.top_valid, "empty status with entries held")
   `SPQ_ASSERT_NOW(a_top_zero, clock, reset, rsp_valid && !rsp_data.top_valid,
      rsp_data.top_value == '0, "top value not zero on an empty queue")
   `SPQ_ASSERT_NOW(a_no_write_idle, clock, reset, !req_stall, !cmd.wr_en,
      "entry memory written while idle")

endmodule

// File: src/spq_ctrl.sv
// Controller state machine for the sorted priority queue.
module spq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  spq_pkg::opcode_type req_op,
   input  spq_pkg::sts_type    sts,
   output logic                req_stall,
   output spq_pkg::cmd_type    cmd
);
   import spq_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      cmd.capture     = 1'b0;
      cmd.idx_sel     = IDX_HOLD;
      cmd.wr_en       = 1'b0;
      cmd.wr_addr     = WA_IDX;
      cmd.wr_shift    = 1'b0;
      cmd.cnt_op      = CNT_HOLD;
      cmd.top_op      = TOP_HOLD;
      cmd.status_load = 1'b0;
      cmd.status      = STATUS_DONE;
      cmd.rsp_load    = 1'b0;
      req_stall       = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (req_op == OP_PUSH) begin
                  if (sts.full) begin
                     cmd.status_load = 1'b1;
                     cmd.status      = STATUS_FULL;
                     state_in        = ST_FINISH;
                  end else if (sts.empty) begin
                     cmd.idx_sel = IDX_ZERO;
                     state_in    = ST_PLACE;
                  end else begin
                     cmd.idx_sel = IDX_LAST;
                     state_in    = ST_SCAN;
                  end
               end else begin
                  if (sts.empty) begin
                     cmd.status_load = 1'b1;
                     cmd.status      = STATUS_EMPTY;
                     state_in        = ST_FINISH;
                  end else if (sts.single) begin
                     cmd.cnt_op      = CNT_DEC;
                     cmd.status_load = 1'b1;
                     cmd.status      = STATUS_DONE;
                     state_in        = ST_FINISH;
                  end else begin
                     cmd.idx_sel = IDX_BELOW_LAST;
                     state_in    = ST_POP_WAIT;
                  end
               end
            end
         end
         ST_SCAN: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = WA_IDX_UP;
            if (sts.greater) begin
               cmd.wr_shift = 1'b1;
               if (sts.idx_zero) begin
                  state_in = ST_PLACE;
               end else begin
                  cmd.idx_sel = IDX_DEC;
               end
            end else begin
               cmd.cnt_op      = CNT_INC;
               cmd.top_op      = TOP_PUSH;
               cmd.status_load = 1'b1;
               cmd.status      = STATUS_DONE;
               state_in        = ST_FINISH;
            end
         end
         ST_PLACE: begin
            cmd.wr_en       = 1'b1;
            cmd.wr_addr     = WA_IDX;
            cmd.cnt_op      = CNT_INC;
            cmd.top_op      = TOP_PUSH;
            cmd.status_load = 1'b1;
            cmd.status      = STATUS_DONE;
            state_in        = ST_FINISH;
         end
         ST_POP_WAIT: begin
            cmd.cnt_op      = CNT_DEC;
            cmd.top_op      = TOP_READ;
            cmd.status_load = 1'b1;
            cmd.status      = STATUS_DONE;
            state_in        = ST_FINISH;
         end
         ST_FINISH: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: src/spq_datapath.sv
// Datapath for the sorted priority queue: entry memory, count, top and result register.
module spq_datapath #(
   parameter int CAPACITY    = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  spq_pkg::req_type  req_data,
   input  spq_pkg::cmd_type  cmd,
   input  logic              rsp_stall,
   output spq_pkg::sts_type  sts,
   output logic              rsp_valid,
   output spq_pkg::rsp_type  rsp_data
);
   import spq_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);

   logic [VALUE_WIDTH-1:0] entries_ff [CAPACITY];

   logic [CW-1:0]                count_ff;
   logic [CW-1:0]                count_in;
   logic [AW-1:0]                idx_ff;
   logic [AW-1:0]                idx_in;
   logic [AW-1:0]                wr_idx;
   logic signed [VALUE_WIDTH-1:0] value_ff;
   logic signed [VALUE_WIDTH-1:0] rd_data_ff;
   logic signed [VALUE_WIDTH-1:0] top_ff;
   logic signed [VALUE_WIDTH-1:0] top_in;
   status_type                   status_ff;
   logic                         rsp_valid_ff;
   rsp_type                      rsp_data_ff;
   rsp_type                      rsp_data_in;

   always_comb begin
      case (cmd.idx_sel)
         IDX_HOLD:       idx_in = idx_ff;
         IDX_ZERO:       idx_in = '0;
         IDX_LAST:       idx_in = AW'(count_ff - CW'(1));
         IDX_BELOW_LAST: idx_in = AW'(count_ff - CW'(2));
         IDX_DEC:        idx_in = idx_ff - AW'(1);
         default:        idx_in = idx_ff;
      endcase
   end

   always_comb begin
      case (cmd.cnt_op)
         CNT_INC: count_in = count_ff + CW'(1);
         CNT_DEC: count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_comb begin
      case (cmd.top_op)
         TOP_PUSH: top_in = ((count_ff == '0) || !(top_ff > value_ff)) ? value_ff : top_ff;
         TOP_READ: top_in = rd_data_ff;
         default:  top_in = top_ff;
      endcase
   end

   assign wr_idx = (cmd.wr_addr == WA_IDX_UP) ? idx_ff + AW'(1) : idx_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         entries_ff[wr_idx] <= cmd.wr_shift ? rd_data_ff : value_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= entries_ff[idx_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      top_ff <= top_in;
      if (cmd.capture) begin
         value_ff <= VALUE_WIDTH'(req_data.value);
      end
      if (cmd.status_load) begin
         status_ff <= cmd.status;
      end
   end

   always_comb begin
      rsp_data_in.status    = status_ff;
      rsp_data_in.count     = COUNT_W'(count_ff);
      rsp_data_in.top_valid = (count_ff != '0);
      rsp_data_in.top_value = (count_ff != '0) ? FIELD_W'(top_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign sts.full     = (count_ff == CW'(CAPACITY));
   assign sts.empty    = (count_ff == '0);
   assign sts.single   = (count_ff == CW'(1));
   assign sts.greater  = (rd_data_ff > value_ff);
   assign sts.idx_zero = (idx_ff == '0);
   assign sts.rsp_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: bench/tb_sorted_priority_queue.sv
// Self-checking testbench for the sorted priority queue: random push/pop traffic with stalls.
module tb_sorted_priority_queue;
   import spq_pkg::*;

   localparam int CAPACITY    = 64;
   localparam int TOTAL_ITEMS = 1200;
   localparam int IDLE_PCT    = 16;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE      = 100;
   localparam int LIMIT       = 400000;

   class spq_scoreboard;
      logic signed [FIELD_W-1:0] held[$];
      rsp_type                   pending[$];
      int                        errors = 0;

      function void note(req_type item);
         rsp_type                   res;
         logic signed [FIELD_W-1:0] v;
         int                        slot;
         v = $signed(item.value);
         res.status = STATUS_DONE;
         if (item.opcode == OP_PUSH) begin
            if (held.size() >= CAPACITY) begin
               res.status = STATUS_FULL;
            end else begin
               slot = 0;
               while (slot < held.size() && held[slot] > v) slot++;
               held.insert(slot, v);
            end
         end else if (held.size() == 0) begin
            res.status = STATUS_EMPTY;
         end else begin
            held.delete(0);
         end
         res.count     = COUNT_W'(held.size());
         res.top_valid = (held.size() != 0);
         res.top_value = (held.size() != 0) ? held[0] : '0;
         pending.insert(pending.size(), res);
      endfunction

      function void check(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            $display("%0t: result with none expected, expected none, got %h", $time, got);
            errors++;
            return;
         end
         want = pending[0];
         pending.delete(0);
         if (got.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, got.status);
            errors++;
         end
         if (got.count !== want.count) begin
            $display("%0t: count mismatch, expected %0d, got %0d", $time, want.count, got.count);
            errors++;
         end
         if (got.top_valid !== want.top_valid) begin
            $display("%0t: top_valid mismatch, expected %0b, got %0b",
                     $time, want.top_valid, got.top_valid);
            errors++;
         end
         if (got.top_value !== want.top_value) begin
            $display("%0t: top_value mismatch, expected %0d, got %0d",
                     $time, want.top_value, got.top_value);
            errors++;
         end
      endfunction

      function int outstanding();
         return pending.size();
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   spq_scoreboard sb;
   bit            calm       = 1'b0;
   int            hold_asked = 0;
   int            items_sent = 0;
   int            cycles     = 0;

   sorted_priority_queue #(
      .CAPACITY(CAPACITY),
      .VALUE_WIDTH(FIELD_W)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic req_type make_req(opcode_type op, logic signed [FIELD_W-1:0] v);
      req_type r;
      r.opcode = op;
      r.value  = v;
      return r;
   endfunction

   function automatic logic signed [FIELD_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0, 1, 2: return FIELD_W'(int'($urandom_range(0, 16)) - 8);
         3: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         4: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF - $urandom_range(0, 3)
                                        : 32'sh8000_0000 + $urandom_range(0, 3);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_item(input req_type item);
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      sb.note(item);
      items_sent++;
   endtask

   task automatic run_mix(input int n, input int push_pct);
      repeat (n) begin
         send_item(make_req(($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP,
                            pick_value()));
      end
   endtask

   task automatic fill_up();
      repeat (CAPACITY - sb.held.size() + $urandom_range(1, 4)) begin
         send_item(make_req(OP_PUSH, pick_value()));
      end
   endtask

   task automatic drain_out();
      repeat (sb.held.size() + $urandom_range(1, 3)) begin
         send_item(make_req(OP_POP, pick_value()));
      end
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
   endtask

   initial begin : receiver
      int hold_seen;
      int hold_left;
      hold_seen = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) sb.check(rsp_data);
         if (hold_asked != hold_seen) begin
            hold_seen = hold_asked;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
         end
      end
   end

   initial begin : stimulus
      logic signed [FIELD_W-1:0] edge_vals [10];
      edge_vals = '{32'sd0, 32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd1, 32'sd1,
                    32'sd5, 32'sd5, 32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd1};
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_item(make_req(OP_POP, 32'sh7FFF_FFFF));
      foreach (edge_vals[i]) send_item(make_req(OP_PUSH, edge_vals[i]));
      repeat (11) send_item(make_req(OP_POP, 32'sh8000_0000));

      fill_up();
      drain_out();
      wait_quiet();

      hold_asked++;
      run_mix(120, 60);
      wait_quiet();

      calm = 1'b1;
      run_mix(150, 55);
      fill_up();
      calm = 1'b0;

      while (items_sent < TOTAL_ITEMS) begin
         case ($urandom_range(0, 5))
            0: fill_up();
            1: drain_out();
            2: run_mix($urandom_range(10, 60), 65);
            3: run_mix($urandom_range(10, 60), 35);
            4: run_mix($urandom_range(10, 60), 50);
            default: wait_quiet();
         endcase
      end

      wait_quiet();
      repeat (SETTLE) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule

// File: sorted_priority_queue.f
+incdir+src
src/spq_pkg.sv
src/spq_ctrl.sv
src/spq_datapath.sv
src/sorted_priority_queue.sv
bench/tb_sorted_priority_queue.sv
